// ===== rtl/qcd_pkg.sv =====
// Shared types, opcodes and the pixel hash of the QOI chunk decoder.
// No dependencies; the core, the pixel table and the op unit use it by scoped names.
package qcd_pkg;

  localparam int TableDepth = 64;
  localparam int TableAw    = $clog2(TableDepth);

  localparam logic [7:0] TAG_RGB  = 8'hFE;
  localparam logic [7:0] TAG_RGBA = 8'hFF;

  localparam logic [1:0] OPC_INDEX = 2'b00;
  localparam logic [1:0] OPC_DIFF  = 2'b01;
  localparam logic [1:0] OPC_LUMA  = 2'b10;
  localparam logic [1:0] OPC_RUN   = 2'b11;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_RGB  = 2'd1,
    OP_RGBA = 2'd2,
    OP_LUMA = 2'd3
  } pending_op_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic               we;
    logic [TableAw-1:0] addr;
    pixel_t             pixel;
  } table_wr_t;

  typedef struct packed {
    logic   emit;
    logic   last;
    pixel_t pixel;
  } op_res_t;

  localparam pixel_t PREV_RESET = '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd255};

  function automatic logic [TableAw-1:0] pixel_hash(input pixel_t px);
    logic [TableAw-1:0] h;
    h = px.red[TableAw-1:0] * TableAw'(3) + px.green[TableAw-1:0] * TableAw'(5)
      + px.blue[TableAw-1:0] * TableAw'(7) + px.alpha[TableAw-1:0] * TableAw'(11);
    return h;
  endfunction

endpackage

// ===== rtl/qcd_chunk_if.sv =====
// Request channel carrying one chunk byte per transfer.
// Depends on nothing.
interface qcd_chunk_if;
  logic       valid;
  logic       ready;
  logic [7:0] chunk_byte;

  modport source (output valid, output chunk_byte, input ready);
  modport sink   (input valid, input chunk_byte, output ready);
endinterface

// ===== rtl/qcd_pixel_if.sv =====
// Request channel carrying one decoded RGBA pixel per transfer.
// Depends on nothing.
interface qcd_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       last_of_run;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output last_of_run, input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input last_of_run, output ready);
endinterface

// ===== rtl/qoi_chunk_decoder_core.sv =====
// QOI chunk stream decoder: one chunk byte per input request, RGBA pixels out.
// Depends on qcd_pkg, qcd_chunk_if, qcd_pixel_if, qcd_color_table, qcd_op_unit.
//
// in_chunk carries chunk bytes only (no header, no end marker); out_pixel carries
// decoded pixels, last_of_run set on the final pixel a byte produces.
// A byte is taken into the decode stage register while the 64-entry pixel table
// is read at its low six bits; from there it is decoded, the table is updated and
// the output register is loaded, whose pixel drives out_pixel until it is taken.
// Bytes are taken one per cycle while out_pixel drains; tag bytes of RGB, RGBA
// and LUMA produce no pixel. A RUN byte holds the decode stage while it emits
// 1 to 62 copies, one per cycle while out_pixel drains; the input waits meanwhile.
// When out_pixel stalls, the output register holds its pixel, the decode stage
// holds a byte that makes a pixel and in_chunk.ready drops once both are full.
// Synchronous reset clears the table valid bits at once (every entry reads as
// zero), sets the previous pixel to opaque black and drops any open op; no
// clearing pass is needed and a byte may be sent in the first cycle after reset.
module qoi_chunk_decoder_core (
  input logic          clk,
  input logic          rst_n,
  qcd_chunk_if.sink    in_chunk,
  qcd_pixel_if.source  out_pixel
);

  logic                s1_valid_r, s1_valid_nxt;
  logic [7:0]          s1_byte_r;
  logic                out_valid_r, out_valid_nxt;
  qcd_pkg::pixel_t     out_pixel_r;
  logic                out_last_r;

  logic                out_free;
  logic                accept;
  logic                s1_done;
  qcd_pkg::pixel_t     tbl_pixel;
  qcd_pkg::op_res_t    res;
  qcd_pkg::table_wr_t  tbl_wr;

  assign out_free       = !out_valid_r || out_pixel.ready;
  assign in_chunk.ready = !s1_valid_r || s1_done;
  assign accept         = in_chunk.valid && in_chunk.ready;

  qcd_color_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_addr  (in_chunk.chunk_byte[qcd_pkg::TableAw-1:0]),
    .wr       (tbl_wr),
    .rd_pixel (tbl_pixel)
  );

  qcd_op_unit u_op (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid_r),
    .s1_byte   (s1_byte_r),
    .out_free  (out_free),
    .tbl_pixel (tbl_pixel),
    .res       (res),
    .done      (s1_done),
    .tbl_wr    (tbl_wr)
  );

  always_comb begin
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_done) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (res.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_pixel.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_r <= in_chunk.chunk_byte;
    end
    if (res.emit) begin
      out_pixel_r <= res.pixel;
      out_last_r  <= res.last;
    end
  end

  assign out_pixel.valid       = out_valid_r;
  assign out_pixel.red         = out_pixel_r.red;
  assign out_pixel.green       = out_pixel_r.green;
  assign out_pixel.blue        = out_pixel_r.blue;
  assign out_pixel.alpha       = out_pixel_r.alpha;
  assign out_pixel.last_of_run = out_last_r;

endmodule

// ===== rtl/qcd_color_table.sv =====
// 64-entry pixel table: synchronous memory, per-entry valid bits, write forwarding.
// Depends on qcd_pkg.
module qcd_color_table (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [qcd_pkg::TableAw-1:0]  rd_addr,
  input  qcd_pkg::table_wr_t           wr,
  output qcd_pkg::pixel_t              rd_pixel
);

  qcd_pkg::pixel_t                    mem [qcd_pkg::TableDepth];
  qcd_pkg::pixel_t                    rd_data_r;
  logic [qcd_pkg::TableAw-1:0]        rd_addr_r;
  logic                               fwd_hit_r;
  qcd_pkg::pixel_t                    fwd_pixel_r;
  logic [qcd_pkg::TableDepth-1:0]     valid_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.pixel;
    end
    if (rd_en) begin
      rd_data_r   <= mem[rd_addr];
      rd_addr_r   <= rd_addr;
      fwd_pixel_r <= wr.pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (wr.we) begin
        valid_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        fwd_hit_r <= wr.we && (wr.addr == rd_addr);
      end
    end
  end

  always_comb begin
    if (fwd_hit_r) begin
      rd_pixel = fwd_pixel_r;
    end else if (valid_r[rd_addr_r]) begin
      rd_pixel = rd_data_r;
    end else begin
      rd_pixel = '0;
    end
  end

endmodule

// ===== rtl/qcd_op_unit.sv =====
// Op decoder: multi-byte op state, previous pixel, run counter and table update.
// Depends on qcd_pkg.
module qcd_op_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s1_valid,
  input  logic [7:0]          s1_byte,
  input  logic                out_free,
  input  qcd_pkg::pixel_t     tbl_pixel,
  output qcd_pkg::op_res_t    res,
  output logic                done,
  output qcd_pkg::table_wr_t  tbl_wr
);

  qcd_pkg::pending_op_t pending_r, pending_nxt;
  logic [2:0]           bytes_left_r, bytes_left_nxt;
  qcd_pkg::pixel_t      prev_r, prev_nxt;
  qcd_pkg::pixel_t      asm_r, asm_nxt;
  logic [5:0]           luma_gd_r, luma_gd_nxt;
  logic [5:0]           run_cnt_r, run_cnt_nxt;

  qcd_pkg::pixel_t      asm_upd;
  qcd_pkg::pixel_t      px;
  logic [1:0]           pos;
  logic [2:0]           total;
  logic                 is_tag;
  logic                 is_run;
  logic                 no_result;
  logic                 run_last;

  assign is_tag = (s1_byte == qcd_pkg::TAG_RGB) || (s1_byte == qcd_pkg::TAG_RGBA);
  assign is_run = (pending_r == qcd_pkg::OP_NONE) && !is_tag
                  && (s1_byte[7:6] == qcd_pkg::OPC_RUN);
  assign run_last = (run_cnt_r == s1_byte[5:0]);
  assign total = (pending_r == qcd_pkg::OP_RGB) ? 3'd3 : 3'd4;
  assign pos = 2'(total - bytes_left_r);

  always_comb begin
    asm_upd = asm_r;
    case (pos)
      2'd0:    asm_upd.red   = s1_byte;
      2'd1:    asm_upd.green = s1_byte;
      2'd2:    asm_upd.blue  = s1_byte;
      default: asm_upd.alpha = s1_byte;
    endcase
  end

  always_comb begin
    px = prev_r;
    unique case (pending_r)
      qcd_pkg::OP_RGB, qcd_pkg::OP_RGBA: px = asm_upd;
      qcd_pkg::OP_LUMA: begin
        px.red   = prev_r.red + {2'b00, luma_gd_r} + {4'b0000, s1_byte[7:4]} - 8'd40;
        px.green = prev_r.green + {2'b00, luma_gd_r} - 8'd32;
        px.blue  = prev_r.blue + {2'b00, luma_gd_r} + {4'b0000, s1_byte[3:0]} - 8'd40;
        px.alpha = prev_r.alpha;
      end
      qcd_pkg::OP_NONE: begin
        case (s1_byte[7:6])
          qcd_pkg::OPC_INDEX: px = tbl_pixel;
          qcd_pkg::OPC_DIFF: begin
            px.red   = prev_r.red + {6'd0, s1_byte[5:4]} + 8'd254;
            px.green = prev_r.green + {6'd0, s1_byte[3:2]} + 8'd254;
            px.blue  = prev_r.blue + {6'd0, s1_byte[1:0]} + 8'd254;
            px.alpha = prev_r.alpha;
          end
          default: px = prev_r;
        endcase
      end
      default: px = prev_r;
    endcase
  end

  always_comb begin
    unique case (pending_r)
      qcd_pkg::OP_RGB, qcd_pkg::OP_RGBA: no_result = (bytes_left_r != 3'd1);
      qcd_pkg::OP_LUMA:                  no_result = 1'b0;
      default: no_result = is_tag || (s1_byte[7:6] == qcd_pkg::OPC_LUMA);
    endcase
  end

  // Outputs
  always_comb begin
    res.emit   = s1_valid && !no_result && out_free;
    res.last   = !is_run || run_last;
    res.pixel  = px;
    done       = s1_valid && (no_result || (out_free && (!is_run || run_last)));
    tbl_wr.we    = done && !no_result;
    tbl_wr.addr  = qcd_pkg::pixel_hash(px);
    tbl_wr.pixel = px;
  end

  // Next state
  always_comb begin
    pending_nxt    = pending_r;
    bytes_left_nxt = bytes_left_r;
    prev_nxt       = prev_r;
    asm_nxt        = asm_r;
    luma_gd_nxt    = luma_gd_r;
    run_cnt_nxt    = run_cnt_r;
    if (done) begin
      run_cnt_nxt = '0;
      if (!no_result) begin
        prev_nxt = px;
      end
      unique case (pending_r)
        qcd_pkg::OP_RGB, qcd_pkg::OP_RGBA: begin
          asm_nxt        = asm_upd;
          bytes_left_nxt = bytes_left_r - 3'd1;
          if (bytes_left_r == 3'd1) begin
            pending_nxt = qcd_pkg::OP_NONE;
          end
        end
        qcd_pkg::OP_LUMA: begin
          pending_nxt    = qcd_pkg::OP_NONE;
          bytes_left_nxt = '0;
        end
        default: begin
          if (s1_byte == qcd_pkg::TAG_RGB) begin
            pending_nxt    = qcd_pkg::OP_RGB;
            bytes_left_nxt = 3'd3;
            asm_nxt        = prev_r;
          end else if (s1_byte == qcd_pkg::TAG_RGBA) begin
            pending_nxt    = qcd_pkg::OP_RGBA;
            bytes_left_nxt = 3'd4;
            asm_nxt        = prev_r;
          end else if (s1_byte[7:6] == qcd_pkg::OPC_LUMA) begin
            pending_nxt    = qcd_pkg::OP_LUMA;
            bytes_left_nxt = 3'd1;
            luma_gd_nxt    = s1_byte[5:0];
          end
        end
      endcase
    end else if (res.emit) begin
      run_cnt_nxt = run_cnt_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r    <= qcd_pkg::OP_NONE;
      bytes_left_r <= '0;
      prev_r       <= qcd_pkg::PREV_RESET;
      asm_r        <= '0;
      luma_gd_r    <= '0;
      run_cnt_r    <= '0;
    end else begin
      pending_r    <= pending_nxt;
      bytes_left_r <= bytes_left_nxt;
      prev_r       <= prev_nxt;
      asm_r        <= asm_nxt;
      luma_gd_r    <= luma_gd_nxt;
      run_cnt_r    <= run_cnt_nxt;
    end
  end

  a_idle_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r == qcd_pkg::OP_NONE |-> bytes_left_r == 3'd0)
    else $error("bytes pending with no op open");

  a_rgb_count: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r == qcd_pkg::OP_RGB |-> bytes_left_r >= 3'd1 && bytes_left_r <= 3'd3)
    else $error("RGB byte count out of range");

  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid && is_run |-> run_cnt_r <= s1_byte[5:0])
    else $error("run copied past its length");

  a_run_restart: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> run_cnt_r == 6'd0)
    else $error("run counter not cleared after a request");

endmodule
